FILE: rtl/core/lfsc_pkg.sv
`timescale 1ns / 1ps

package lfsc_pkg;

  // line sensor geometry
  localparam int unsigned LINE_WIDTH = 640;
  localparam int unsigned LINE_MID   = LINE_WIDTH / 2;
  localparam int unsigned LINE_W     = 10;
  localparam int unsigned CORR_W     = LINE_W;

  // soft start: ramp steps is a power of two so base/steps is a shift
  localparam int unsigned RAMP_SHIFT = 3;
  localparam int unsigned RAMP_STEPS = 1 << RAMP_SHIFT;
  localparam int unsigned RAMP_W     = $clog2(RAMP_STEPS + 1);

  localparam int          STEP_DELTA = 200;
  localparam int unsigned LOST_LIMIT = 50;
  localparam int unsigned LOST_W     = $clog2(LOST_LIMIT + 1);

  // field and register widths
  localparam int unsigned SPEED_W   = 16;
  localparam int unsigned WIDE_W    = SPEED_W + 2;
  localparam int unsigned SEL_W     = 4;
  localparam int unsigned TOP_W     = 11;
  localparam int unsigned REV_W     = 12;
  localparam int unsigned GAIN_W    = 4;
  localparam int unsigned DEAD_W    = 9;
  localparam int unsigned BAND_W    = 12;
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOP_SPEED     = 3'd0,
    REG_REVERSE_LIMIT = 3'd1,
    REG_STEER_GAIN    = 3'd2,
    REG_DEAD_BAND     = 3'd3,
    REG_STRAIGHT_BAND = 3'd4
  } cfg_reg_e;

  localparam logic [1:0] SLOPE_UP   = 2'd1;
  localparam logic [1:0] SLOPE_DOWN = 2'd2;

  localparam logic [1:0] OBST_LEFT  = 2'd1;
  localparam logic [1:0] OBST_RIGHT = 2'd2;

  typedef enum logic [2:0] {
    MC_BACKWARD = 3'd0,
    MC_STOPPED  = 3'd1,
    MC_STRAIGHT = 3'd2,
    MC_LEFT     = 3'd3,
    MC_RIGHT    = 3'd4
  } motion_e;

  typedef enum logic [2:0] {
    DRV_IDLE    = 3'd0,
    DRV_SPIN_L  = 3'd1,
    DRV_SPIN_R  = 3'd2,
    DRV_FOLLOW  = 3'd3,
    DRV_REVERSE = 3'd4,
    DRV_SEARCH  = 3'd5
  } drive_e;

  typedef struct packed {
    logic [SEL_W-1:0]  selector_pos;
    logic [1:0]        slope;
    logic              pushed;
    logic              halt_mode;
    logic [1:0]        obstacle_side;
    logic [LINE_W-1:0] line_pos;
  } item_t;

  typedef struct packed {
    drive_e                    mode;
    logic signed [SPEED_W-1:0] base;
    logic [RAMP_W-1:0]         ramp;
    logic signed [CORR_W-1:0]  corr;
  } decision_t;

endpackage

FILE: rtl/core/lfsc_state.sv
`timescale 1ns / 1ps

module lfsc_state import lfsc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  item_t                    item_i,
  input  logic [TOP_W-1:0]         top_speed_i,
  input  logic signed [REV_W-1:0]  reverse_limit_i,
  input  logic [DEAD_W-1:0]        dead_band_i,
  output decision_t                dec_o
);

  logic [SEL_W-1:0]          prev_q;
  logic                      primed_q;
  logic signed [SPEED_W-1:0] base_q, level_q;
  logic [RAMP_W-1:0]         ramp_q, ramp_d;
  logic [LOST_W-1:0]         lost_q, lost_d;

  logic [SEL_W-1:0]          prev_eff;
  logic signed [SEL_W:0]     dif;
  logic                      cw;
  logic                      flat;
  logic signed [WIDE_W-1:0]  top_s, rev_s, s, s_step, nb_wide;
  logic signed [SPEED_W-1:0] nb;
  logic signed [LINE_W:0]    corr_w;
  logic [LINE_W:0]           mag;
  logic                      line_ok;

  assign prev_eff = primed_q ? prev_q : item_i.selector_pos;
  assign dif  = $signed({1'b0, item_i.selector_pos}) - $signed({1'b0, prev_eff});
  assign cw   = (dif > 0 && dif < 5'sd9) || (dif < -5'sd8);
  // slope code three behaves as level
  assign flat = (item_i.slope != SLOPE_UP) && (item_i.slope != SLOPE_DOWN);

  assign top_s = $signed({{(WIDE_W-TOP_W){1'b0}}, top_speed_i});
  assign rev_s = WIDE_W'(reverse_limit_i);

  // next base speed: overrides, selector step, clamp
  always_comb begin
    logic ovr;
    logic signed [WIDE_W-1:0] ovr_val;
    ovr     = 1'b0;
    ovr_val = top_s;
    s       = WIDE_W'(base_q);
    if (base_q > 0) begin
      if (item_i.pushed || item_i.slope == SLOPE_DOWN) begin
        ovr = 1'b1;
      end else if (item_i.slope == SLOPE_UP) begin
        ovr     = 1'b1;
        ovr_val = top_s >>> 3;
      end else begin
        s = WIDE_W'(level_q);
      end
    end else if (base_q < 0 && item_i.pushed) begin
      ovr     = 1'b1;
      ovr_val = top_s >>> 2;
    end
    s_step = cw ? s + WIDE_W'(STEP_DELTA) : s - WIDE_W'(STEP_DELTA);
    if (ovr) begin
      nb_wide = ovr_val;
    end else if (dif == 0) begin
      nb_wide = s;
    end else if (s_step > top_s) begin
      nb_wide = top_s;
    end else if (s_step < rev_s) begin
      nb_wide = rev_s;
    end else begin
      nb_wide = s_step;
    end
  end

  assign nb = nb_wide[SPEED_W-1:0];

  assign corr_w  = $signed({1'b0, item_i.line_pos}) - $signed((LINE_W + 1)'(LINE_MID));
  assign mag     = corr_w[LINE_W] ? (LINE_W + 1)'(-corr_w) : (LINE_W + 1)'(corr_w);
  assign line_ok = (item_i.line_pos != '0) && (item_i.line_pos < LINE_W'(LINE_WIDTH));

  // drive decision and ramp / lost-line counters
  always_comb begin
    dec_o.mode = DRV_IDLE;
    dec_o.base = nb;
    dec_o.corr = '0;
    ramp_d     = ramp_q;
    lost_d     = lost_q;
    if (item_i.halt_mode || nb != 0) begin
      if (item_i.obstacle_side == OBST_LEFT) begin
        dec_o.mode = DRV_SPIN_L;
      end else if (item_i.obstacle_side == OBST_RIGHT) begin
        dec_o.mode = DRV_SPIN_R;
      end else if (line_ok && nb > 0) begin
        dec_o.mode = DRV_FOLLOW;
        lost_d     = '0;
        if (mag >= (LINE_W + 1)'(dead_band_i)) begin
          dec_o.corr = corr_w[CORR_W-1:0];
        end
        if (ramp_q < RAMP_W'(RAMP_STEPS)) begin
          ramp_d = ramp_q + 1'b1;
        end
      end else if (nb < 0) begin
        dec_o.mode = DRV_REVERSE;
      end else if (lost_q == LOST_W'(LOST_LIMIT)) begin
        dec_o.mode = DRV_SEARCH;
        ramp_d     = '0;
      end else begin
        lost_d = lost_q + 1'b1;
      end
    end
    dec_o.ramp = ramp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= '0;
      primed_q <= 1'b0;
      base_q   <= '0;
      level_q  <= '0;
      ramp_q   <= '0;
      lost_q   <= '0;
    end else if (step_i) begin
      prev_q   <= item_i.selector_pos;
      primed_q <= 1'b1;
      base_q   <= nb;
      if (!item_i.pushed && flat) begin
        level_q <= nb;
      end
      ramp_q   <= ramp_d;
      lost_q   <= lost_d;
    end
  end

endmodule

FILE: rtl/core/line_follow_speed_controller.sv
`timescale 1ns / 1ps

// an accepted request passes the s1, s2, s3 and output registers before its result is valid
// throughput: one request per cycle while out_ready_i is high; four register stages with per-stage stalls,
//   so requests keep flowing into empty stages while a result waits at the output
// reset: asynchronous, active low; valid and configuration registers return to their reset values,
//   speed state clears and the first tick after reset captures the selector

module line_follow_speed_controller import lfsc_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_W-1:0]          cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [SEL_W-1:0]          selector_pos_i,
  input  logic [1:0]                slope_i,
  input  logic                      pushed_i,
  input  logic                      halt_mode_i,
  input  logic [1:0]                obstacle_side_i,
  input  logic [LINE_W-1:0]         line_pos_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [SPEED_W-1:0] right_speed_o,
  output logic signed [SPEED_W-1:0] left_speed_o,
  output logic [2:0]                motion_class_o
);

  logic [TOP_W-1:0]         top_speed_q;
  logic signed [REV_W-1:0]  reverse_limit_q;
  logic [GAIN_W-1:0]        steer_gain_q;
  logic [DEAD_W-1:0]        dead_band_q;
  logic [BAND_W-1:0]        straight_band_q;

  logic                      s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  item_t                     s1_item_q;
  decision_t                 dec, s2_dec_q;
  logic signed [SPEED_W-1:0] s3_r_q, s3_l_q;
  logic signed [SPEED_W-1:0] out_r_q, out_l_q;
  motion_e                   out_mc_q, mc;
  logic                      en1, en2, en3, en_out, step;

  logic [TOP_W-3:0]          quarter;
  logic signed [WIDE_W-1:0]  quarter_s, base_s, r_w, l_w;
  logic [SPEED_W:0]          sp;
  logic signed [SPEED_W-1:0] steer;
  logic signed [SPEED_W:0]   diff;
  logic [SPEED_W:0]          absd;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_speed_q     <= TOP_W'(800);
      reverse_limit_q <= -REV_W'(200);
      steer_gain_q    <= GAIN_W'(2);
      dead_band_q     <= DEAD_W'(10);
      straight_band_q <= BAND_W'(10);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_TOP_SPEED:     top_speed_q     <= cfg_data_i[TOP_W-1:0];
        REG_REVERSE_LIMIT: reverse_limit_q <= cfg_data_i[REV_W-1:0];
        REG_STEER_GAIN:    steer_gain_q    <= cfg_data_i[GAIN_W-1:0];
        REG_DEAD_BAND:     dead_band_q     <= cfg_data_i[DEAD_W-1:0];
        REG_STRAIGHT_BAND: straight_band_q <= cfg_data_i[BAND_W-1:0];
        default: ;
      endcase
    end
  end

  // per-stage stall chain
  assign en_out     = !out_valid_q || out_ready_i;
  assign en3        = !s3_valid_q || en_out;
  assign en2        = !s2_valid_q || en3;
  assign en1        = !s1_valid_q || en2;
  assign in_ready_o = en1;
  assign step       = s1_valid_q && en2;

  lfsc_state u_state (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .item_i          (s1_item_q),
    .top_speed_i     (top_speed_q),
    .reverse_limit_i (reverse_limit_q),
    .dead_band_i     (dead_band_q),
    .dec_o           (dec)
  );

  // wheel speeds from the registered decision
  assign quarter   = top_speed_q[TOP_W-1:2];
  assign quarter_s = $signed({{(WIDE_W-TOP_W+2){1'b0}}, quarter});
  assign base_s    = WIDE_W'(s2_dec_q.base);
  // base is positive when following, so the divide is a plain shift
  assign sp        = (SPEED_W + 1)'(s2_dec_q.ramp)
                   * (SPEED_W + 1)'(s2_dec_q.base[SPEED_W-1:RAMP_SHIFT]);
  assign steer     = SPEED_W'($signed({1'b0, steer_gain_q})) * SPEED_W'(s2_dec_q.corr);

  always_comb begin
    r_w = '0;
    l_w = '0;
    case (s2_dec_q.mode)
      DRV_SPIN_L: begin
        r_w = quarter_s;
        l_w = -quarter_s;
      end
      DRV_SPIN_R: begin
        r_w = -quarter_s;
        l_w = quarter_s;
      end
      DRV_FOLLOW: begin
        r_w = $signed({1'b0, sp}) - WIDE_W'(steer);
        l_w = $signed({1'b0, sp}) + WIDE_W'(steer);
      end
      DRV_REVERSE: begin
        r_w = base_s;
        l_w = base_s;
      end
      DRV_SEARCH: begin
        r_w = -base_s;
        l_w = base_s;
      end
      default: ;
    endcase
  end

  // motion class from the wrapped wheel speeds
  assign diff = (SPEED_W + 1)'(s3_r_q) - (SPEED_W + 1)'(s3_l_q);
  assign absd = diff[SPEED_W] ? (SPEED_W + 1)'(-diff) : (SPEED_W + 1)'(diff);

  always_comb begin
    if (s3_r_q < 0 && s3_l_q < 0) begin
      mc = MC_BACKWARD;
    end else if (s3_r_q == 0 && s3_l_q == 0) begin
      mc = MC_STOPPED;
    end else if (absd < (SPEED_W + 1)'(straight_band_q)) begin
      mc = MC_STRAIGHT;
    end else if (s3_r_q > s3_l_q) begin
      mc = MC_LEFT;
    end else begin
      mc = MC_RIGHT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1)    s1_valid_q  <= in_valid_i;
      if (en2)    s2_valid_q  <= s1_valid_q;
      if (en3)    s3_valid_q  <= s2_valid_q;
      if (en_out) out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      s1_item_q.selector_pos  <= selector_pos_i;
      s1_item_q.slope         <= slope_i;
      s1_item_q.pushed        <= pushed_i;
      s1_item_q.halt_mode     <= halt_mode_i;
      s1_item_q.obstacle_side <= obstacle_side_i;
      s1_item_q.line_pos      <= line_pos_i;
    end
    if (step) begin
      s2_dec_q <= dec;
    end
    if (en3 && s2_valid_q) begin
      s3_r_q <= r_w[SPEED_W-1:0];
      s3_l_q <= l_w[SPEED_W-1:0];
    end
    if (en_out && s3_valid_q) begin
      out_r_q  <= s3_r_q;
      out_l_q  <= s3_l_q;
      out_mc_q <= mc;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign right_speed_o  = out_r_q;
  assign left_speed_o   = out_l_q;
  assign motion_class_o = out_mc_q;

`ifndef SYNTHESIS
  a_follow_ramp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && s2_dec_q.mode == DRV_FOLLOW |->
      s2_dec_q.base > 0 && s2_dec_q.ramp != 0 && s2_dec_q.ramp <= RAMP_W'(RAMP_STEPS))
    else $error("follow decision with bad base or ramp");

  a_reverse_neg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && s2_dec_q.mode == DRV_REVERSE |-> s2_dec_q.base < 0)
    else $error("reverse decision with non-negative base");

  a_stopped_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && motion_class_o == MC_STOPPED |-> right_speed_o == 0 && left_speed_o == 0)
    else $error("stopped class with moving wheels");

  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> s1_valid_q)
    else $error("accepted request lost at input stage");
`endif

endmodule

FILE: sim/tb_line_follow_speed_controller.sv
`timescale 1ns / 1ps

module tb_line_follow_speed_controller;
  import lfsc_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int PHASES          = 8;
  localparam int TICKS_PER_PHASE = 160;
  localparam int SETTLE          = 6;

  localparam logic [1:0] SLOPE_LEVEL = 2'd0;
  localparam logic [1:0] SLOPE_ODD   = 2'd3;
  localparam logic [1:0] OBST_NONE   = 2'd0;
  localparam logic [1:0] OBST_ODD    = 2'd3;

  typedef struct packed {
    logic signed [SPEED_W-1:0] rspd;
    logic signed [SPEED_W-1:0] lspd;
    motion_e                   mc;
  } wheel_cmd_t;

  typedef struct {
    item_t      tick;
    bit         known;
    wheel_cmd_t want;
  } dir_row_t;

  logic                      clk_i           = 1'b0;
  logic                      rst_ni          = 1'b0;
  logic                      cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_idx_i       = '0;
  logic [CFG_W-1:0]          cfg_data_i      = '0;
  logic                      in_valid_i      = 1'b0;
  logic                      in_ready_o;
  logic [SEL_W-1:0]          selector_pos_i  = '0;
  logic [1:0]                slope_i         = '0;
  logic                      pushed_i        = 1'b0;
  logic                      halt_mode_i     = 1'b0;
  logic [1:0]                obstacle_side_i = '0;
  logic [LINE_W-1:0]         line_pos_i      = '0;
  logic                      out_valid_o;
  logic                      out_ready_i     = 1'b0;
  logic signed [SPEED_W-1:0] right_speed_o;
  logic signed [SPEED_W-1:0] left_speed_o;
  logic [2:0]                motion_class_o;

  line_follow_speed_controller dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .selector_pos_i (selector_pos_i),
    .slope_i        (slope_i),
    .pushed_i       (pushed_i),
    .halt_mode_i    (halt_mode_i),
    .obstacle_side_i(obstacle_side_i),
    .line_pos_i     (line_pos_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .right_speed_o  (right_speed_o),
    .left_speed_o   (left_speed_o),
    .motion_class_o (motion_class_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of the registers and the speed state
  logic [TOP_W-1:0]        top_q;
  logic signed [REV_W-1:0] rev_q;
  logic [GAIN_W-1:0]       gain_q;
  logic [DEAD_W-1:0]       dead_q;
  logic [BAND_W-1:0]       band_q;
  logic [SEL_W-1:0]        sel_seen;
  bit                      sel_seen_ok;
  int                      base_spd;
  int                      level_spd;
  int                      ramp_cnt;
  int                      lost_cnt;

  wheel_cmd_t pending_cmds[$];
  dir_row_t   dir_tab[$];
  int         mismatches = 0;
  int         cycles     = 0;
  int         snd_idle   = 0;
  int         rcv_stall  = 0;

  // stimulus shaping state
  logic [SEL_W-1:0] sel_drv = '0;
  bit               climb   = 1'b1;
  int               lost_run = 0;

  function automatic int to_speed(input int v);
    logic signed [SPEED_W-1:0] w;
    w = v[SPEED_W-1:0];
    return int'(w);
  endfunction

  function automatic wheel_cmd_t predict_wheels(input item_t t);
    logic [1:0] slope;
    int         top, s, dif, nb, quarter, corr, mag, sp, r, l, d;
    wheel_cmd_t w;
    top     = int'(top_q);
    quarter = top / 4;
    slope   = (t.slope == SLOPE_ODD) ? SLOPE_LEVEL : t.slope;
    if (!sel_seen_ok) begin
      sel_seen    = t.selector_pos;
      sel_seen_ok = 1'b1;
    end
    dif      = int'(t.selector_pos) - int'(sel_seen);
    sel_seen = t.selector_pos;
    s        = base_spd;
    if (s > 0 && (t.pushed || slope == SLOPE_DOWN)) begin
      nb = top;
    end else if (s > 0 && slope == SLOPE_UP) begin
      nb = top / 8;
    end else if (s < 0 && t.pushed) begin
      nb = top / 4;
    end else begin
      if (s > 0)
        s = level_spd;
      if (dif == 0) begin
        nb = s;
      end else begin
        // short clockwise turn, including the wrap past the last position
        if ((dif > 0 && dif < 9) || dif < -8)
          s += STEP_DELTA;
        else
          s -= STEP_DELTA;
        // upper clamp wins when the limits cross
        if (s > top)
          nb = top;
        else if (s < int'(rev_q))
          nb = int'(rev_q);
        else
          nb = s;
      end
    end
    base_spd = to_speed(nb);
    if (!t.pushed && slope == SLOPE_LEVEL)
      level_spd = base_spd;

    r = 0;
    l = 0;
    if (t.halt_mode || base_spd != 0) begin
      if (t.obstacle_side == OBST_LEFT) begin
        r = quarter;
        l = -quarter;
      end else if (t.obstacle_side == OBST_RIGHT) begin
        r = -quarter;
        l = quarter;
      end else if (t.line_pos != 0 && int'(t.line_pos) < int'(LINE_WIDTH) &&
                   base_spd > 0) begin
        corr     = int'(t.line_pos) - int'(LINE_MID);
        mag      = (corr < 0) ? -corr : corr;
        lost_cnt = 0;
        if (mag < int'(dead_q))
          corr = 0;
        if (ramp_cnt < int'(RAMP_STEPS))
          ramp_cnt++;
        sp = ramp_cnt * (base_spd / int'(RAMP_STEPS));
        r  = sp - int'(gain_q) * corr;
        l  = sp + int'(gain_q) * corr;
      end else if (base_spd < 0) begin
        r = base_spd;
        l = base_spd;
      end else if (lost_cnt == int'(LOST_LIMIT)) begin
        // search spin once the line has been gone long enough
        ramp_cnt = 0;
        r        = -base_spd;
        l        = base_spd;
      end else begin
        lost_cnt++;
      end
    end
    r = to_speed(r);
    l = to_speed(l);
    d = (r > l) ? r - l : l - r;
    w.rspd = r[SPEED_W-1:0];
    w.lspd = l[SPEED_W-1:0];
    if (r < 0 && l < 0)
      w.mc = MC_BACKWARD;
    else if (r == 0 && l == 0)
      w.mc = MC_STOPPED;
    else if (d < int'(band_q))
      w.mc = MC_STRAIGHT;
    else if (r > l)
      w.mc = MC_LEFT;
    else
      w.mc = MC_RIGHT;
    return w;
  endfunction

  function automatic item_t rand_tick();
    item_t t;
    int    pick, step;
    if ($urandom_range(99) < 8) begin
      // noise over the full field widths
      t.selector_pos  = SEL_W'($urandom);
      t.slope         = 2'($urandom);
      t.pushed        = 1'($urandom);
      t.halt_mode     = 1'($urandom);
      t.obstacle_side = 2'($urandom);
      t.line_pos      = LINE_W'($urandom);
      sel_drv         = t.selector_pos;
    end else begin
      if ($urandom_range(99) < 3)
        climb = !climb;
      pick = $urandom_range(99);
      if (pick < 35)
        step = 0;
      else if (pick < 80)
        step = $urandom_range(2, 1);
      else if (pick < 90)
        step = -1;
      else
        step = $urandom_range(15);
      if (!climb && pick >= 35 && pick < 90)
        step = -step;
      sel_drv        = sel_drv + SEL_W'(step);
      t.selector_pos = sel_drv;
      t.slope        = ($urandom_range(99) < 75) ? SLOPE_LEVEL : 2'($urandom_range(3, 1));
      t.pushed       = ($urandom_range(99) < 8);
      t.halt_mode    = ($urandom_range(99) < 25);
      pick           = $urandom_range(99);
      if (pick < 6)
        t.obstacle_side = OBST_LEFT;
      else if (pick < 12)
        t.obstacle_side = OBST_RIGHT;
      else if (pick < 14)
        t.obstacle_side = OBST_ODD;
      else
        t.obstacle_side = OBST_NONE;
      // long stretches without a line reach the search spin
      if (lost_run == 0 && $urandom_range(99) < 4)
        lost_run = $urandom_range(70, 45);
      if (lost_run > 0 || $urandom_range(99) < 3) begin
        if (lost_run > 0) begin
          lost_run--;
          t.obstacle_side = OBST_NONE;
        end
        t.line_pos = $urandom_range(1) ? LINE_W'(0) :
                     LINE_W'($urandom_range(1023, LINE_WIDTH));
      end else if ($urandom_range(99) < 30) begin
        t.line_pos = LINE_W'($urandom_range(LINE_MID + 24, LINE_MID - 24));
      end else begin
        t.line_pos = LINE_W'($urandom_range(LINE_WIDTH - 1, 1));
      end
    end
    return t;
  endfunction

  task automatic add_row(input logic [SEL_W-1:0] sel, input logic [1:0] slope,
                         input logic push, input logic halt, input logic [1:0] obst,
                         input logic [LINE_W-1:0] line, input bit known = 1'b0,
                         input int r = 0, input int l = 0, input motion_e mc = MC_STOPPED);
    dir_row_t row;
    row.tick      = '{sel, slope, push, halt, obst, line};
    row.known     = known;
    row.want.rspd = SPEED_W'(r);
    row.want.lspd = SPEED_W'(l);
    row.want.mc   = mc;
    dir_tab.push_back(row);
  endtask

  task automatic load_cfg(input int top, input int rev, input int gain, input int dead,
                          input int band);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_TOP_SPEED;
    cfg_data_i <= CFG_W'(top);
    @(posedge clk_i);
    cfg_idx_i  <= REG_REVERSE_LIMIT;
    cfg_data_i <= CFG_W'(rev);
    @(posedge clk_i);
    cfg_idx_i  <= REG_STEER_GAIN;
    cfg_data_i <= CFG_W'(gain);
    @(posedge clk_i);
    cfg_idx_i  <= REG_DEAD_BAND;
    cfg_data_i <= CFG_W'(dead);
    @(posedge clk_i);
    cfg_idx_i  <= REG_STRAIGHT_BAND;
    cfg_data_i <= CFG_W'(band);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    top_q    = TOP_W'(top);
    rev_q    = REV_W'(rev);
    gain_q   = GAIN_W'(gain);
    dead_q   = DEAD_W'(dead);
    band_q   = BAND_W'(band);
  endtask

  task automatic send_tick(input item_t t, input wheel_cmd_t w);
    while ($urandom_range(99) < snd_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    selector_pos_i  <= t.selector_pos;
    slope_i         <= t.slope;
    pushed_i        <= t.pushed;
    halt_mode_i     <= t.halt_mode;
    obstacle_side_i <= t.obstacle_side;
    line_pos_i      <= t.line_pos;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_cmds.push_back(w);
  endtask

  task automatic wait_drained(input int settle);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin : result_check
    wheel_cmd_t w;
    out_ready_i <= ($urandom_range(99) >= rcv_stall);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_cmds.size() == 0) begin
        $display("%0t: result with no request pending: right %0d left %0d class %0d",
                 $time, right_speed_o, left_speed_o, motion_class_o);
        mismatches++;
      end else begin
        w = pending_cmds.pop_front();
        if (right_speed_o !== w.rspd || left_speed_o !== w.lspd ||
            motion_class_o !== w.mc) begin
          $display("%0t: expected right %0d left %0d class %0d, got %0d %0d %0d",
                   $time, w.rspd, w.lspd, w.mc, right_speed_o, left_speed_o,
                   motion_class_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    wheel_cmd_t w;
    item_t      t;
    top_q       = TOP_W'(800);
    rev_q       = -REV_W'(200);
    gain_q      = GAIN_W'(2);
    dead_q      = DEAD_W'(10);
    band_q      = BAND_W'(10);
    sel_seen    = '0;
    sel_seen_ok = 1'b0;
    base_spd    = 0;
    level_spd   = 0;
    ramp_cnt    = 0;
    lost_cnt    = 0;

    // first tick only captures the selector
    add_row(4'd5, SLOPE_LEVEL, 1'b0, 1'b0, OBST_NONE, 10'd320, 1'b1, 0, 0, MC_STOPPED);
    // zero base speed still drives while halted
    add_row(4'd5, SLOPE_LEVEL, 1'b0, 1'b1, OBST_LEFT, 10'd0, 1'b1, 200, -200, MC_LEFT);
    add_row(4'd5, SLOPE_LEVEL, 1'b0, 1'b1, OBST_RIGHT, 10'd0, 1'b1, -200, 200, MC_RIGHT);
    add_row(4'd5, SLOPE_LEVEL, 1'b0, 1'b1, OBST_ODD, 10'd0, 1'b1, 0, 0, MC_STOPPED);
    add_row(4'd6, SLOPE_LEVEL, 1'b0, 1'b0, OBST_NONE, 10'd320);
    add_row(4'd7, SLOPE_LEVEL, 1'b0, 1'b0, OBST_NONE, 10'd639);
    add_row(4'd15, SLOPE_LEVEL, 1'b0, 1'b0, OBST_NONE, 10'd1);
    add_row(4'd7, SLOPE_LEVEL, 1'b0, 1'b0, OBST_NONE, 10'd330);
    add_row(4'd0, SLOPE_LEVEL, 1'b0, 1'b0, OBST_NONE, 10'd329);
    add_row(4'd15, SLOPE_LEVEL, 1'b0, 1'b0, OBST_NONE, 10'd320);
    add_row(4'd0, SLOPE_LEVEL, 1'b0, 1'b0, OBST_NONE, 10'd320);
    add_row(4'd0, SLOPE_UP, 1'b0, 1'b0, OBST_NONE, 10'd320);
    add_row(4'd0, SLOPE_DOWN, 1'b0, 1'b0, OBST_NONE, 10'd320);
    add_row(4'd0, SLOPE_ODD, 1'b0, 1'b0, OBST_NONE, 10'd320);
    add_row(4'd0, SLOPE_LEVEL, 1'b1, 1'b0, OBST_NONE, 10'd320);
    add_row(4'd0, SLOPE_LEVEL, 1'b0, 1'b0, OBST_NONE, 10'd640);
    add_row(4'd0, SLOPE_LEVEL, 1'b0, 1'b0, OBST_NONE, 10'd1023);
    add_row(4'd15, SLOPE_LEVEL, 1'b0, 1'b0, OBST_NONE, 10'd0);
    add_row(4'd14, SLOPE_LEVEL, 1'b0, 1'b0, OBST_NONE, 10'd0);
    add_row(4'd13, SLOPE_LEVEL, 1'b0, 1'b0, OBST_NONE, 10'd0);
    add_row(4'd13, SLOPE_LEVEL, 1'b1, 1'b0, OBST_NONE, 10'd0);
    add_row(4'd13, SLOPE_LEVEL, 1'b0, 1'b1, OBST_NONE, 10'd320);
    add_row(4'd15, SLOPE_LEVEL, 1'b0, 1'b1, OBST_NONE, 10'd512);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      w = predict_wheels(dir_tab[i].tick);
      if (dir_tab[i].known)
        w = dir_tab[i].want;
      send_tick(dir_tab[i].tick, w);
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_drained(SETTLE);
      case (p % 4)
        0: begin
          snd_idle  = 0;
          rcv_stall = 0;
        end
        1: begin
          snd_idle  = 56;
          rcv_stall = 0;
        end
        2: begin
          snd_idle  = 0;
          rcv_stall = 56;
        end
        default: begin
          snd_idle  = 15;
          rcv_stall = 15;
        end
      endcase
      case (p)
        0: load_cfg(2000, -2000, 15, 0, 0);
        1: load_cfg(0, 0, 0, 511, 4095);
        2: load_cfg(800, -200, 2, 10, 10);
        default: begin
          load_cfg($urandom_range(2000), 0 - int'($urandom_range(2000)),
                   $urandom_range(15),
                   ($urandom_range(99) < 70) ? $urandom_range(40) : $urandom_range(511),
                   ($urandom_range(99) < 70) ? $urandom_range(300) : $urandom_range(4095));
        end
      endcase
      for (int k = 0; k < TICKS_PER_PHASE; k++) begin
        // occasionally let the pipeline run dry before the next tick
        if ($urandom_range(199) == 0)
          wait_drained(0);
        t = rand_tick();
        send_tick(t, predict_wheels(t));
      end
    end

    wait_drained(SETTLE);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
